FILE: hw/rtl/serial_camera_capture_host_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the serial camera capture host
// Concurrent checks that the sequencer and the job queue write in the same form.
// ---------------------------------------------------------------------------
`ifndef SERIAL_CAMERA_CAPTURE_HOST_UNIT_ASSERT_SVH
`define SERIAL_CAMERA_CAPTURE_HOST_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define SCCH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scch assertion failed");

// Antecedent implies consequent in the following cycle
`define SCCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scch assertion failed");

`endif

FILE: hw/rtl/scch_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scch_pkg
// Types and protocol constants shared by the serial camera capture host.
// ---------------------------------------------------------------------------
package scch_pkg;

   // Message framing
   localparam int MSG_BYTES     = 6;
   localparam int PKG_HDR_BYTES = 4;
   localparam int PKG_TRL_BYTES = 2;
   localparam int POS_W         = 10;

   // Event kinds on the input channel
   localparam logic [1:0] MODE_CONNECT = 2'd0;
   localparam logic [1:0] MODE_PICTURE = 2'd1;
   localparam logic [1:0] MODE_RX_BYTE = 2'd2;
   localparam logic [1:0] MODE_TIMEOUT = 2'd3;

   // Status codes
   localparam logic [2:0] ST_BUSY      = 3'd0;
   localparam logic [2:0] ST_READY     = 3'd1;
   localparam logic [2:0] ST_PIC_DONE  = 3'd2;
   localparam logic [2:0] ST_LINK_FAIL = 3'd3;
   localparam logic [2:0] ST_PIC_FAIL  = 3'd4;

   // Command bytes
   localparam logic [7:0] CMD_START     = 8'hAA;
   localparam logic [7:0] ID_INIT       = 8'h01;
   localparam logic [7:0] ID_GET_PIC    = 8'h04;
   localparam logic [7:0] ID_SNAPSHOT   = 8'h05;
   localparam logic [7:0] ID_SET_SIZE   = 8'h06;
   localparam logic [7:0] ID_SYNC       = 8'h0D;
   localparam logic [7:0] ID_ACK        = 8'h0E;
   localparam logic [7:0] SIZE_KIND_PKG = 8'h08;
   localparam logic [7:0] PIC_KIND_SNAP = 8'h01;

   // Register map
   localparam logic [1:0] REG_RETRY = 2'd0;
   localparam logic [1:0] REG_PKG   = 2'd1;
   localparam logic [1:0] REG_COLOR = 2'd2;
   localparam logic [1:0] REG_RES   = 2'd3;

   localparam logic [5:0]       RETRY_RESET = 6'd60;
   localparam logic [POS_W-1:0] PKG_RESET   = 10'd512;
   localparam logic [7:0]       COLOR_RESET = 8'h07;
   localparam logic [7:0]       RES_RESET   = 8'h07;
   localparam logic [POS_W-1:0] PKG_MIN     = 10'd8;

   // Job queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [5:0]       sync_retry_limit;
      logic [POS_W-1:0] package_bytes;
      logic [7:0]       init_color;
      logic [7:0]       init_resolution;
   } cfg_type;

   // One job: optional pixel, optional six-byte command, optional status
   typedef struct packed {
      logic                        pix_en;
      logic [7:0]                  pix;
      logic                        cmd_en;
      logic [MSG_BYTES-2:0][7:0]   arg;
      logic                        st_en;
      logic [2:0]                  st;
   } job_type;

endpackage

FILE: hw/rtl/scch_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scch_csr
// APB-style configuration registers of the camera host.
// ---------------------------------------------------------------------------
module scch_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output scch_pkg::cfg_type cfg
);
   import scch_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_fire;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_fire = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_retry_limit <= RETRY_RESET;
         cfg_ff.package_bytes    <= PKG_RESET;
         cfg_ff.init_color       <= COLOR_RESET;
         cfg_ff.init_resolution  <= RES_RESET;
      end else if (wr_fire) begin
         unique case (reg_idx)
            REG_RETRY: cfg_ff.sync_retry_limit <= pwdata[5:0];
            REG_PKG:   cfg_ff.package_bytes    <= pwdata[POS_W-1:0];
            REG_COLOR: cfg_ff.init_color       <= pwdata[7:0];
            REG_RES:   cfg_ff.init_resolution  <= pwdata[7:0];
            default:   ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_RETRY: prdata = {26'd0, cfg_ff.sync_retry_limit};
         REG_PKG:   prdata = {22'd0, cfg_ff.package_bytes};
         REG_COLOR: prdata = {24'd0, cfg_ff.init_color};
         REG_RES:   prdata = {24'd0, cfg_ff.init_resolution};
         default:   prdata = '0;
      endcase
   end

endmodule

FILE: hw/rtl/scch_front.sv
`timescale 1ns / 1ps
`include "serial_camera_capture_host_unit_assert.svh"
// ---------------------------------------------------------------------------
// scch_front
// Protocol sequencer: classifies each event and emits at most one job per event.
// ---------------------------------------------------------------------------
module scch_front #(
   parameter int MAX_PACKAGE_BYTES = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  scch_pkg::cfg_type cfg,
   input  logic              in_accept,
   input  logic [1:0]        in_mode,
   input  logic [7:0]        in_rx_byte,
   output logic              job_valid,
   output scch_pkg::job_type job
);
   import scch_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_SYNC_ACK, PH_CAM_SYNC, PH_INIT_PEND, PH_INIT_ACK,
      PH_SIZE_ACK, PH_SNAP_ACK, PH_PIC_ACK, PH_DATA_HDR, PH_PACKAGES
   } phase_type;

   localparam logic [POS_W:0] PKG_MAX = (POS_W+1)'(MAX_PACKAGE_BYTES);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [5:0]       tries_ff, tries_in;
   logic [15:0]      count_ff, count_in;
   logic             link_ff, link_in;
   logic             setup_ff, setup_in;
   logic [7:0]       reply_ff [MSG_BYTES];

   logic             reply_wr;
   logic [2:0]       reply_idx;
   logic             do_init, do_finish, finish_ok;
   logic [POS_W-1:0] pkg_eff, data_max, data_size;
   logic [15:0]      size_raw;
   logic [POS_W:0]   data_end, pkg_end;

   function automatic job_type cmd_job(input logic [7:0] b1, input logic [7:0] b2,
                                       input logic [7:0] b3, input logic [7:0] b4,
                                       input logic [7:0] b5);
      job_type j;
      j        = '0;
      j.cmd_en = 1'b1;
      j.arg    = {b5, b4, b3, b2, b1};
      return j;
   endfunction

   function automatic job_type stat_job(input logic [2:0] st);
      job_type j;
      j       = '0;
      j.st_en = 1'b1;
      j.st    = st;
      return j;
   endfunction

   function automatic logic prefix_ok(input logic [7:0] r0, input logic [7:0] r1,
                                      input logic [7:0] r2, input logic [7:0] b1,
                                      input logic [7:0] b2);
      return (r0 == CMD_START) && (r1 == b1) && (r2 == b2);
   endfunction

   // Saturate package length and derive data field bounds
   always_comb begin
      if (cfg.package_bytes < PKG_MIN) begin
         pkg_eff = PKG_MIN;
      end else if ({1'b0, cfg.package_bytes} > PKG_MAX) begin
         pkg_eff = PKG_MAX[POS_W-1:0];
      end else begin
         pkg_eff = cfg.package_bytes;
      end
      data_max = pkg_eff - POS_W'(PKG_HDR_BYTES + PKG_TRL_BYTES);
      size_raw = {reply_ff[3], reply_ff[2]};
      if (size_raw > {{(16-POS_W){1'b0}}, data_max}) begin
         data_size = data_max;
      end else begin
         data_size = size_raw[POS_W-1:0];
      end
      data_end = {1'b0, data_size} + (POS_W+1)'(PKG_HDR_BYTES);
      pkg_end  = data_end + (POS_W+1)'(PKG_TRL_BYTES - 1);
   end

   // Sequence the protocol for the accepted event
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      tries_in  = tries_ff;
      count_in  = count_ff;
      link_in   = link_ff;
      setup_in  = setup_ff;
      reply_wr  = 1'b0;
      reply_idx = pos_ff[2:0];
      do_init   = 1'b0;
      do_finish = 1'b0;
      finish_ok = 1'b0;
      job       = '0;
      if (in_accept) begin
         if (in_mode == MODE_CONNECT) begin
            link_in  = 1'b0;
            setup_in = 1'b0;
            tries_in = 6'd1;
            pos_in   = '0;
            count_in = '0;
            phase_in = PH_SYNC_ACK;
            job      = cmd_job(ID_SYNC, 8'h00, 8'h00, 8'h00, 8'h00);
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (in_mode == MODE_PICTURE) begin
                     if (link_ff && setup_ff) begin
                        phase_in = PH_SNAP_ACK;
                        pos_in   = '0;
                        job      = cmd_job(ID_SNAPSHOT, 8'h00, 8'h00, 8'h00, 8'h00);
                     end else begin
                        job = stat_job(ST_PIC_FAIL);
                     end
                  end
               end
               PH_INIT_PEND: begin
                  do_init = 1'b1;
               end
               PH_PACKAGES: begin
                  if (in_mode == MODE_TIMEOUT) begin
                     phase_in = PH_IDLE;
                     pos_in   = '0;
                     job      = stat_job(ST_PIC_DONE);
                  end else if (in_mode == MODE_RX_BYTE) begin
                     if (pos_ff < POS_W'(PKG_HDR_BYTES)) begin
                        // Collect package header
                        reply_wr = 1'b1;
                        pos_in   = pos_ff + 1'b1;
                     end else begin
                        if ({1'b0, pos_ff} >= pkg_end) begin
                           // Package complete: ACK with the running count
                           count_in = count_ff + 1'b1;
                           pos_in   = '0;
                           job      = cmd_job(ID_ACK, 8'h00, 8'h00, count_in[7:0],
                                              count_in[15:8]);
                        end else begin
                           pos_in = pos_ff + 1'b1;
                        end
                        job.pix_en = ({1'b0, pos_ff} < data_end);
                        job.pix    = in_rx_byte;
                     end
                  end
               end
               default: begin
                  if (in_mode == MODE_TIMEOUT) begin
                     pos_in = '0;
                     unique case (phase_ff)
                        PH_SYNC_ACK: begin
                           if (tries_ff < cfg.sync_retry_limit) begin
                              tries_in = tries_ff + 1'b1;
                              job      = cmd_job(ID_SYNC, 8'h00, 8'h00, 8'h00, 8'h00);
                           end else begin
                              link_in = 1'b0;
                              do_init = 1'b1;
                           end
                        end
                        PH_CAM_SYNC: begin
                           link_in = 1'b0;
                           do_init = 1'b1;
                        end
                        PH_INIT_ACK, PH_SIZE_ACK: begin
                           do_finish = 1'b1;
                        end
                        default: begin
                           phase_in = PH_IDLE;
                           job      = stat_job(ST_PIC_FAIL);
                        end
                     endcase
                  end else if (in_mode == MODE_RX_BYTE) begin
                     reply_wr = (pos_ff < POS_W'(MSG_BYTES));
                     pos_in   = pos_ff + 1'b1;
                     if (pos_ff >= POS_W'(MSG_BYTES - 1)) begin
                        // Full reply: the last byte is still on the input
                        pos_in = '0;
                        unique case (phase_ff)
                           PH_SYNC_ACK: begin
                              if (prefix_ok(reply_ff[0], reply_ff[1], reply_ff[2],
                                            ID_ACK, ID_SYNC)) begin
                                 phase_in = PH_CAM_SYNC;
                              end else begin
                                 link_in = 1'b0;
                                 do_init = 1'b1;
                              end
                           end
                           PH_CAM_SYNC: begin
                              link_in  = prefix_ok(reply_ff[0], reply_ff[1], reply_ff[2],
                                                   ID_SYNC, 8'h00)
                                         && (reply_ff[3] == 8'h00)
                                         && (reply_ff[4] == 8'h00)
                                         && (in_rx_byte == 8'h00);
                              phase_in = PH_INIT_PEND;
                              job      = cmd_job(ID_ACK, ID_SYNC, 8'h00, 8'h00, 8'h00);
                           end
                           PH_INIT_ACK: begin
                              if (prefix_ok(reply_ff[0], reply_ff[1], reply_ff[2],
                                            ID_ACK, ID_INIT)) begin
                                 phase_in = PH_SIZE_ACK;
                                 job      = cmd_job(ID_SET_SIZE, SIZE_KIND_PKG,
                                                    pkg_eff[7:0],
                                                    {{(16-POS_W){1'b0}}, pkg_eff[POS_W-1:8]},
                                                    8'h00);
                              end else begin
                                 do_finish = 1'b1;
                              end
                           end
                           PH_SIZE_ACK: begin
                              do_finish = 1'b1;
                              finish_ok = prefix_ok(reply_ff[0], reply_ff[1], reply_ff[2],
                                                    ID_ACK, ID_SET_SIZE);
                           end
                           PH_SNAP_ACK: begin
                              if (prefix_ok(reply_ff[0], reply_ff[1], reply_ff[2],
                                            ID_ACK, ID_SNAPSHOT)) begin
                                 phase_in = PH_PIC_ACK;
                                 job      = cmd_job(ID_GET_PIC, PIC_KIND_SNAP, 8'h00, 8'h00,
                                                    8'h00);
                              end else begin
                                 phase_in = PH_IDLE;
                                 job      = stat_job(ST_PIC_FAIL);
                              end
                           end
                           PH_PIC_ACK: begin
                              if (prefix_ok(reply_ff[0], reply_ff[1], reply_ff[2],
                                            ID_ACK, ID_GET_PIC)) begin
                                 phase_in = PH_DATA_HDR;
                              end else begin
                                 phase_in = PH_IDLE;
                                 job      = stat_job(ST_PIC_FAIL);
                              end
                           end
                           default: begin
                              // Data header read: request the first package
                              phase_in = PH_PACKAGES;
                              count_in = '0;
                              job      = cmd_job(ID_ACK, 8'h00, 8'h00, 8'h00, 8'h00);
                           end
                        endcase
                     end
                  end
               end
            endcase
         end
      end
      if (do_init) begin
         phase_in = PH_INIT_ACK;
         pos_in   = '0;
         job      = cmd_job(ID_INIT, 8'h00, cfg.init_color, 8'h00, cfg.init_resolution);
      end
      if (do_finish) begin
         setup_in = finish_ok;
         phase_in = PH_IDLE;
         pos_in   = '0;
         job      = stat_job((link_ff && finish_ok) ? ST_READY : ST_LINK_FAIL);
      end
   end

   assign job_valid = job.pix_en | job.cmd_en | job.st_en;

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         tries_ff <= '0;
         count_ff <= '0;
         link_ff  <= 1'b0;
         setup_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         tries_ff <= tries_in;
         count_ff <= count_in;
         link_ff  <= link_in;
         setup_ff <= setup_in;
      end
   end

   // Capture reply bytes
   always_ff @(posedge clock) begin
      if (reply_wr) begin
         reply_ff[reply_idx] <= in_rx_byte;
      end
   end

   `SCCH_ASSERT_IMPLY(a_picture_needs_link, clock, reset,
      phase_ff == PH_SNAP_ACK || phase_ff == PH_PIC_ACK || phase_ff == PH_DATA_HDR ||
      phase_ff == PH_PACKAGES, link_ff && setup_ff)
   `SCCH_ASSERT_NEXT(a_connect_restarts, clock, reset,
      in_accept && in_mode == MODE_CONNECT, phase_ff == PH_SYNC_ACK && tries_ff == 6'd1)
   `SCCH_ASSERT_IMPLY(a_job_from_event, clock, reset, job_valid, in_accept)

endmodule

FILE: hw/rtl/scch_queue.sv
`timescale 1ns / 1ps
`include "serial_camera_capture_host_unit_assert.svh"
// ---------------------------------------------------------------------------
// scch_queue
// Short job queue between the protocol sequencer and the result emitter.
// ---------------------------------------------------------------------------
module scch_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  scch_pkg::job_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output scch_pkg::job_type rd_data,
   output logic              empty
);
   import scch_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   cnt_ff;
   logic              do_wr, do_rd;

   assign full    = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // Store jobs
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   `SCCH_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
      cnt_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
   `SCCH_ASSERT_NEXT(a_count_tracks_push, clock, reset, do_wr && !do_rd,
      cnt_ff == $past(cnt_ff) + 1'b1)

endmodule

FILE: hw/rtl/scch_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scch_back
// Result emitter: expands each job into pixel, command and status transactions.
// ---------------------------------------------------------------------------
module scch_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  scch_pkg::job_type q_data,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic              rsp_tx_valid,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_pixel_valid,
   output logic [7:0]        rsp_pixel_byte,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);
   import scch_pkg::*;

   typedef enum logic [1:0] {SEG_PIX, SEG_CMD, SEG_ST} seg_type;

   localparam logic [2:0] IDX_LAST = 3'(MSG_BYTES - 1);

   job_type    job_ff;
   seg_type    seg_ff, first_seg;
   logic [2:0] idx_ff, arg_sel;
   logic       cur_vld_ff;
   logic       fire, is_last, load;

   // Decide whether the shown transaction ends its job
   always_comb begin
      unique case (seg_ff)
         SEG_PIX: is_last = ~job_ff.cmd_en & ~job_ff.st_en;
         SEG_CMD: is_last = (idx_ff == IDX_LAST) & ~job_ff.st_en;
         SEG_ST:  is_last = 1'b1;
         default: is_last = 1'b1;
      endcase
   end

   assign fire      = pop & cur_vld_ff;
   assign load      = ~q_empty & (~cur_vld_ff | (fire & is_last));
   assign q_pop     = load;
   assign empty     = ~cur_vld_ff;
   assign first_seg = q_data.pix_en ? SEG_PIX : (q_data.cmd_en ? SEG_CMD : SEG_ST);

   // Step through the job
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         seg_ff     <= SEG_PIX;
         idx_ff     <= '0;
      end else if (load) begin
         cur_vld_ff <= 1'b1;
         seg_ff     <= first_seg;
         idx_ff     <= '0;
      end else if (fire) begin
         if (is_last) begin
            cur_vld_ff <= 1'b0;
         end else begin
            unique case (seg_ff)
               SEG_PIX: begin
                  seg_ff <= job_ff.cmd_en ? SEG_CMD : SEG_ST;
                  idx_ff <= '0;
               end
               SEG_CMD: begin
                  if (idx_ff == IDX_LAST) begin
                     seg_ff <= SEG_ST;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Hold the job payload
   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= q_data;
      end
   end

   // Drive result fields
   assign arg_sel         = idx_ff - 1'b1;
   assign rsp_tx_valid    = (seg_ff == SEG_CMD);
   assign rsp_tx_byte     = (seg_ff != SEG_CMD) ? 8'h00 :
                            (idx_ff == '0) ? CMD_START : job_ff.arg[arg_sel];
   assign rsp_pixel_valid = (seg_ff == SEG_PIX);
   assign rsp_pixel_byte  = (seg_ff == SEG_PIX) ? job_ff.pix : 8'h00;
   assign rsp_status      = (seg_ff == SEG_ST) ? job_ff.st : ST_BUSY;
   assign rsp_last        = is_last;

endmodule

FILE: hw/rtl/serial_camera_capture_host_unit.sv
`timescale 1ns / 1ps
// Serial camera capture host, top level.
// Input channel (push/full): one event per transaction: connect, take picture,
// a byte received from the camera, or a read timeout.
// Result channel (empty/pop): bytes to send to the camera, JPEG payload bytes
// with package header and trailer removed, and status reports; rsp_last marks
// the final transaction caused by one event. An event may cause no result.
// Configuration: APB-style port, retry limit, package length, init bytes, to be
// written only while the block is idle; the block itself does not enforce this.
// Path: an accepted event's job is written into the job queue and then loaded
// into the emitter's job register, from which the result ports are driven.
// Throughput: the sequencer takes one event per cycle while its 4-entry job
// queue has room; the emitter sends one transaction per cycle while pop is held,
// and an event causes at most 6 results.
// A stalled receiver fills the job queue, after which full rises.
// Reset: configuration returns to defaults, the link is down and the
// sequencer is idle; no clearing pass is needed.
// ---------------------------------------------------------------------------
// serial_camera_capture_host_unit
// Host side of a six-byte-command serial JPEG camera link.
// ---------------------------------------------------------------------------
module serial_camera_capture_host_unit #(
   parameter int MAX_PACKAGE_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   // Event queue
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_rx_byte,
   // Result queue
   output logic        empty,
   input  logic        pop,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_pixel_valid,
   output logic [7:0]  rsp_pixel_byte,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   // Configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import scch_pkg::*;

   cfg_type cfg;
   job_type job, q_data;
   logic    accept, job_valid, q_full, q_empty, q_pop;

   assign full   = q_full;
   assign accept = push & ~q_full;

   scch_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   scch_front #(
      .MAX_PACKAGE_BYTES (MAX_PACKAGE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_accept  (accept),
      .in_mode    (req_mode),
      .in_rx_byte (req_rx_byte),
      .job_valid  (job_valid),
      .job        (job)
   );

   scch_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_valid),
      .wr_data (job),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   scch_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_data),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_byte  (rsp_pixel_byte),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
